// File: design/vgn_pkg.sv
// shared types and constants of the volume gradient normalizer
package vgn_pkg;

  localparam int RegIdxW = 3;
  localparam int CfgDataW = 9;

  localparam logic [RegIdxW-1:0] REG_VOL_WIDTH    = 3'd0;
  localparam logic [RegIdxW-1:0] REG_VOL_HEIGHT   = 3'd1;
  localparam logic [RegIdxW-1:0] REG_VOL_DEPTH    = 3'd2;
  localparam logic [RegIdxW-1:0] REG_CHANNEL_MODE = 3'd3;

  localparam logic MODE_SAMPLE = 1'b0;
  localparam logic MODE_DRAIN  = 1'b1;

  localparam logic [7:0]  GRAD_MID   = 8'd127;
  localparam logic [7:0]  STRENGTH_ON = 8'd255;
  localparam logic [17:0] SCALE_SQ   = 18'd16129;

  typedef logic [7:0] samp_t;
  typedef logic signed [8:0] diff_t;

  typedef struct packed {
    logic  start;
    diff_t dx;
    diff_t dy;
    diff_t dz;
  } qreq_t;

  typedef struct packed {
    logic  done;
    samp_t gx;
    samp_t gy;
    samp_t gz;
    samp_t strength;
  } qres_t;

endpackage

// File: design/vgn_ram.sv
// generic simple dual port ram with registered read
module vgn_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32768
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

// File: design/vgn_quant.sv
// unit gradient quantizer built around one shared multiplier
module vgn_quant (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  vgn_pkg::qreq_t req_i,
  output vgn_pkg::qres_t res_o
);
  import vgn_pkg::*;

  typedef enum logic [2:0] {
    Q_IDLE, Q_SQ, Q_RHS, Q_TT, Q_CMP, Q_DONE
  } qstate_e;

  qstate_e     state_q;
  logic [7:0]  mag_q [3];
  logic        neg_q [3];
  logic [15:0] sq_q [3];
  logic [17:0] s_q;
  logic [29:0] rhs_q;
  logic [13:0] tt_q;
  logic [6:0]  q_q;
  logic [2:0]  bit_q;
  logic [1:0]  c_q;
  samp_t       res_q [3];

  logic [17:0] mul_a, mul_b;
  logic [35:0] prod;
  logic [6:0]  trial;
  logic [6:0]  q_next;
  logic        hit;

  assign trial = q_q | (7'd1 << bit_q);

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_q)
      Q_SQ: begin
        mul_a = 18'(mag_q[c_q]);
        mul_b = 18'(mag_q[c_q]);
      end
      Q_RHS: begin
        mul_a = 18'(sq_q[c_q]);
        mul_b = SCALE_SQ;
      end
      Q_TT: begin
        mul_a = 18'(trial);
        mul_b = 18'(trial);
      end
      Q_CMP: begin
        mul_a = 18'(tt_q);
        mul_b = s_q;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // a zero gradient keeps every component at the midpoint
  assign prod   = mul_a * mul_b;
  assign hit    = (s_q != '0) && (prod <= 36'(rhs_q));
  assign q_next = hit ? trial : q_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= Q_IDLE;
      c_q     <= '0;
      bit_q   <= '0;
    end else begin
      unique case (state_q)
        Q_IDLE: begin
          if (req_i.start) begin
            mag_q[0] <= req_i.dx[8] ? 8'(-req_i.dx) : req_i.dx[7:0];
            mag_q[1] <= req_i.dy[8] ? 8'(-req_i.dy) : req_i.dy[7:0];
            mag_q[2] <= req_i.dz[8] ? 8'(-req_i.dz) : req_i.dz[7:0];
            neg_q[0] <= req_i.dx[8];
            neg_q[1] <= req_i.dy[8];
            neg_q[2] <= req_i.dz[8];
            s_q      <= '0;
            c_q      <= '0;
            state_q  <= Q_SQ;
          end
        end
        Q_SQ: begin
          sq_q[c_q] <= prod[15:0];
          s_q       <= s_q + prod[17:0];
          if (c_q == 2'd2) begin
            c_q     <= '0;
            state_q <= Q_RHS;
          end else begin
            c_q <= c_q + 2'd1;
          end
        end
        Q_RHS: begin
          rhs_q   <= prod[29:0];
          q_q     <= '0;
          bit_q   <= 3'd6;
          state_q <= Q_TT;
        end
        Q_TT: begin
          tt_q    <= prod[13:0];
          state_q <= Q_CMP;
        end
        Q_CMP: begin
          q_q <= q_next;
          if (bit_q == 3'd0) begin
            res_q[c_q] <= neg_q[c_q] ? GRAD_MID - 8'(q_next) : GRAD_MID + 8'(q_next);
            if (c_q == 2'd2) begin
              state_q <= Q_DONE;
            end else begin
              c_q     <= c_q + 2'd1;
              state_q <= Q_RHS;
            end
          end else begin
            bit_q   <= bit_q - 3'd1;
            state_q <= Q_TT;
          end
        end
        Q_DONE: begin
          state_q <= Q_IDLE;
        end
        default: state_q <= Q_IDLE;
      endcase
    end
  end

  assign res_o.done     = state_q == Q_DONE;
  assign res_o.gx       = res_q[0];
  assign res_o.gy       = res_q[1];
  assign res_o.gz       = res_q[2];
  assign res_o.strength = (s_q != '0) ? STRENGTH_ON : 8'd0;

  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == Q_SQ) |-> (c_q != 2'd3))
    else $error("square index out of range");
  a_done_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == Q_DONE) |=> (state_q == Q_IDLE))
    else $error("done not single cycle");
  a_cmp_from_tt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == Q_CMP) |-> ($past(state_q) == Q_TT))
    else $error("compare without trial square");

endmodule

// File: design/volume_gradient_normalizer_unit.sv
// streaming 3d central difference gradient with unit vector quantization
//
// input channel: valid/stall beats of mode_i and voxel_i. mode 0 is a voxel
// in raster order, mode 1 a drain tick that releases one result of the last
// slice once the whole volume has arrived. output channel: valid/stall beats
// of grad_x/y/z, strength and last. the result for voxel n leaves on the
// beat of voxel n+w*h.
// config: cfg_we_i writes cfg_data_i into register cfg_idx_i (width,
// height, depth, channel mode); the user must write only while the block
// is idle, the block does not enforce it; a write restarts the volume.
// one beat is taken at a time. a drain tick or a sample with a result waits
// on six neighbor reads from the single read port of the window ram and
// on the single 18x18 multiplier of the quantizer: three squares, then per
// component one scale product and seven bit trials, each a trial square
// and a compare.
// the result sits in an output register; a stalled receiver holds the block
// after it has finished the next result.
// reset clears counters and restores default dimensions; ram contents stay
// undefined and are never read before being written.
module volume_gradient_normalizer_unit #(
  parameter int MAX_WIDTH  = 128,
  parameter int MAX_HEIGHT = 128,
  parameter int MAX_DEPTH  = 256
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [vgn_pkg::RegIdxW-1:0]         cfg_idx_i,
  input  logic [vgn_pkg::CfgDataW-1:0]        cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic                                mode_i,
  input  logic [31:0]                         voxel_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [7:0]                          grad_x_o,
  output logic [7:0]                          grad_y_o,
  output logic [7:0]                          grad_z_o,
  output logic [7:0]                          strength_o,
  output logic                                last_o
);
  import vgn_pkg::*;

  localparam int WINDOW = 2 * MAX_WIDTH * MAX_HEIGHT;
  localparam int AW     = $clog2(WINDOW);
  localparam int CWW    = $clog2(MAX_WIDTH + 1);
  localparam int CWH    = $clog2(MAX_HEIGHT + 1);
  localparam int CWD    = $clog2(MAX_DEPTH + 1);
  localparam int WHW    = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);
  localparam int CNTW   = $clog2(MAX_WIDTH * MAX_HEIGHT * MAX_DEPTH + 1);

  localparam logic [2:0] NB_XL = 3'd0;
  localparam logic [2:0] NB_XH = 3'd1;
  localparam logic [2:0] NB_YL = 3'd2;
  localparam logic [2:0] NB_YH = 3'd3;
  localparam logic [2:0] NB_ZL = 3'd4;
  localparam logic [2:0] NB_ZH = 3'd5;

  typedef enum logic [3:0] {
    S_IDLE, S_PREP1, S_PREP2, S_DEC, S_RD, S_RDL, S_QNT, S_RES, S_WR
  } state_e;

  state_e          state_q;
  logic [7:0]      cfg_w_q, cfg_h_q;
  logic [8:0]      cfg_d_q;
  logic            cfg_ch_q;
  logic [2:0]      k_q;
  logic            mode_q;
  samp_t           val_q;
  samp_t           nb_q [6];
  logic [WHW-1:0]  wh_q;
  logic [CNTW-1:0] total_q, acc_q, em_q;
  logic [AW-1:0]   wp_q, rp_q;
  logic [CWW-1:0]  x_q;
  logic [CWH-1:0]  y_q;
  logic [CWD-1:0]  z_q;
  logic            qstart_q;
  logic            out_valid_q;
  samp_t           gx_q, gy_q, gz_q, st_q;
  logic            last_q;

  logic [CWW-1:0]  w_c;
  logic [CWH-1:0]  h_c;
  logic [CWD-1:0]  d_c;
  logic            nb_use, nb_up;
  logic [AW:0]     nb_off, up_sum, dn_sum;
  logic [AW-1:0]   raddr;
  samp_t           rdata;
  logic            ram_we;
  samp_t           samp_in;
  qreq_t           q_req;
  qres_t           q_res;
  logic            out_free;

  always_comb begin
    if (cfg_w_q < 8'd2)          w_c = CWW'(2);
    else if (cfg_w_q > MAX_WIDTH) w_c = CWW'(MAX_WIDTH);
    else                          w_c = CWW'(cfg_w_q);
    if (cfg_h_q < 8'd2)           h_c = CWH'(2);
    else if (cfg_h_q > MAX_HEIGHT) h_c = CWH'(MAX_HEIGHT);
    else                           h_c = CWH'(cfg_h_q);
    if (cfg_d_q < 9'd2)           d_c = CWD'(2);
    else if (cfg_d_q > MAX_DEPTH) d_c = CWD'(MAX_DEPTH);
    else                          d_c = CWD'(cfg_d_q);
  end

  always_comb begin
    nb_use = 1'b0;
    nb_up  = 1'b0;
    nb_off = '0;
    unique case (k_q)
      NB_XL: begin
        nb_use = x_q != '0;
        nb_off = (AW+1)'(1);
      end
      NB_XH: begin
        nb_use = (CWW+1)'(x_q) + (CWW+1)'(1) < (CWW+1)'(w_c);
        nb_up  = 1'b1;
        nb_off = (AW+1)'(1);
      end
      NB_YL: begin
        nb_use = y_q != '0;
        nb_off = (AW+1)'(w_c);
      end
      NB_YH: begin
        nb_use = (CWH+1)'(y_q) + (CWH+1)'(1) < (CWH+1)'(h_c);
        nb_up  = 1'b1;
        nb_off = (AW+1)'(w_c);
      end
      NB_ZL: begin
        nb_use = z_q != '0;
        nb_off = (AW+1)'(wh_q);
      end
      default: begin
        nb_use = (CWD+1)'(z_q) + (CWD+1)'(1) < (CWD+1)'(d_c);
        nb_up  = 1'b1;
        nb_off = (AW+1)'(wh_q);
      end
    endcase
  end

  always_comb begin
    up_sum = (AW+1)'(rp_q) + nb_off;
    if (up_sum >= (AW+1)'(WINDOW)) up_sum = up_sum - (AW+1)'(WINDOW);
    if ((AW+1)'(rp_q) >= nb_off) dn_sum = (AW+1)'(rp_q) - nb_off;
    else                         dn_sum = (AW+1)'(rp_q) + (AW+1)'(WINDOW) - nb_off;
    if (!nb_use)    raddr = rp_q;
    else if (nb_up) raddr = up_sum[AW-1:0];
    else            raddr = dn_sum[AW-1:0];
  end

  assign ram_we  = (state_q == S_WR);
  assign samp_in = cfg_ch_q ? voxel_i[31:24] : voxel_i[7:0];

  vgn_ram #(
    .WIDTH(8),
    .DEPTH(WINDOW)
  ) u_window (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(wp_q),
    .wdata_i(val_q),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  assign q_req.start = qstart_q;
  assign q_req.dx    = diff_t'({1'b0, nb_q[0]}) - diff_t'({1'b0, nb_q[1]});
  assign q_req.dy    = diff_t'({1'b0, nb_q[2]}) - diff_t'({1'b0, nb_q[3]});
  assign q_req.dz    = diff_t'({1'b0, nb_q[4]}) - diff_t'({1'b0, nb_q[5]});

  vgn_quant u_quant (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (q_req),
    .res_o (q_res)
  );

  assign out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cfg_w_q     <= 8'd128;
      cfg_h_q     <= 8'd128;
      cfg_d_q     <= 9'd256;
      cfg_ch_q    <= 1'b0;
      k_q         <= '0;
      acc_q       <= '0;
      em_q        <= '0;
      wp_q        <= '0;
      rp_q        <= '0;
      x_q         <= '0;
      y_q         <= '0;
      z_q         <= '0;
      qstart_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      qstart_q <= 1'b0;
      if (out_valid_q && !out_stall_i && state_q != S_RES) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          REG_VOL_WIDTH:    cfg_w_q  <= cfg_data_i[7:0];
          REG_VOL_HEIGHT:   cfg_h_q  <= cfg_data_i[7:0];
          REG_VOL_DEPTH:    cfg_d_q  <= cfg_data_i;
          REG_CHANNEL_MODE: cfg_ch_q <= cfg_data_i[0];
          default: ;
        endcase
        if (cfg_idx_i == REG_VOL_WIDTH || cfg_idx_i == REG_VOL_HEIGHT ||
            cfg_idx_i == REG_VOL_DEPTH || cfg_idx_i == REG_CHANNEL_MODE) begin
          acc_q <= '0;
          em_q  <= '0;
          wp_q  <= '0;
          rp_q  <= '0;
          x_q   <= '0;
          y_q   <= '0;
          z_q   <= '0;
        end
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            mode_q  <= mode_i;
            val_q   <= samp_in;
            state_q <= S_PREP1;
          end
        end
        S_PREP1: begin
          wh_q    <= WHW'(w_c * h_c);
          state_q <= S_PREP2;
        end
        S_PREP2: begin
          total_q <= CNTW'(wh_q * d_c);
          state_q <= S_DEC;
        end
        S_DEC: begin
          k_q <= '0;
          if (mode_q == MODE_SAMPLE) begin
            if (acc_q >= total_q)             state_q <= S_IDLE;
            else if (acc_q >= CNTW'(wh_q))    state_q <= S_RD;
            else                              state_q <= S_WR;
          end else begin
            if (acc_q < total_q || em_q >= total_q) state_q <= S_IDLE;
            else                                   state_q <= S_RD;
          end
        end
        S_RD: begin
          if (k_q != '0) nb_q[k_q - 3'd1] <= rdata;
          if (k_q == NB_ZH) state_q <= S_RDL;
          else              k_q <= k_q + 3'd1;
        end
        S_RDL: begin
          nb_q[NB_ZH] <= (mode_q == MODE_SAMPLE) ? val_q : rdata;
          qstart_q    <= 1'b1;
          state_q     <= S_QNT;
        end
        S_QNT: begin
          if (q_res.done) state_q <= S_RES;
        end
        S_RES: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            gx_q        <= q_res.gx;
            gy_q        <= q_res.gy;
            gz_q        <= q_res.gz;
            st_q        <= q_res.strength;
            last_q      <= em_q == total_q - CNTW'(1);
            if (mode_q == MODE_DRAIN && em_q + CNTW'(1) >= total_q) begin
              acc_q <= '0;
              em_q  <= '0;
              wp_q  <= '0;
              rp_q  <= '0;
              x_q   <= '0;
              y_q   <= '0;
              z_q   <= '0;
            end else begin
              em_q <= em_q + CNTW'(1);
              rp_q <= ((AW+1)'(rp_q) + (AW+1)'(1) == (AW+1)'(WINDOW)) ?
                      '0 : rp_q + AW'(1);
              if ((CWW+1)'(x_q) + (CWW+1)'(1) == (CWW+1)'(w_c)) begin
                x_q <= '0;
                if ((CWH+1)'(y_q) + (CWH+1)'(1) == (CWH+1)'(h_c)) begin
                  y_q <= '0;
                  z_q <= z_q + CWD'(1);
                end else begin
                  y_q <= y_q + CWH'(1);
                end
              end else begin
                x_q <= x_q + CWW'(1);
              end
            end
            if (mode_q == MODE_SAMPLE) begin
              state_q <= S_WR;
            end else begin
              state_q <= S_IDLE;
            end
          end
        end
        S_WR: begin
          acc_q   <= acc_q + CNTW'(1);
          wp_q    <= ((AW+1)'(wp_q) + (AW+1)'(1) == (AW+1)'(WINDOW)) ?
                     '0 : wp_q + AW'(1);
          state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign in_stall_o  = state_q != S_IDLE;
  assign out_valid_o = out_valid_q;
  assign grad_x_o    = gx_q;
  assign grad_y_o    = gy_q;
  assign grad_z_o    = gz_q;
  assign strength_o  = st_q;
  assign last_o      = last_q;

  a_em_le_acc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    em_q <= acc_q)
    else $error("more results than samples");
  a_done_in_qnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_res.done |-> (state_q == S_QNT))
    else $error("quantizer finished outside wait state");
  a_out_from_res: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) == S_RES))
    else $error("output beat not from result state");
  a_wp_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (AW+1)'(wp_q) < (AW+1)'(WINDOW))
    else $error("write pointer out of window");

endmodule
